[rtl/bcq_pkg.sv]
`default_nettype none
package bcq_pkg;

  localparam int THRESHOLD_W = 5;
  localparam int LIMIT_W     = 16;
  localparam int RUN_OUT_W   = 16;
  localparam int TIME_W      = 32;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  // configuration register indexes
  localparam cfg_index_t REG_LEFT_DEFECT  = 2'd0;
  localparam cfg_index_t REG_RIGHT_DEFECT = 2'd1;
  localparam cfg_index_t REG_THRESHOLD    = 2'd2;
  localparam cfg_index_t REG_LIMIT        = 2'd3;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 5'd2;
  localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = 16'd1000;

  typedef struct packed {
    logic              left_outer_pressed;
    logic              left_inner_pressed;
    logic              right_inner_pressed;
    logic              right_outer_pressed;
    logic              qualify_enable;
    logic [TIME_W-1:0] frame_time;
  } sample_item_t;

  typedef struct packed {
    logic                 contact_left;
    logic                 contact_right;
    logic [RUN_OUT_W-1:0] run_length_left;
    logic [RUN_OUT_W-1:0] run_length_right;
    logic [TIME_W-1:0]    last_contact_left;
    logic [TIME_W-1:0]    last_contact_right;
  } result_item_t;

  // per-foot report travelling from a foot tracker to the top level
  typedef struct packed {
    logic                 contact;
    logic [RUN_OUT_W-1:0] run_length;
    logic [TIME_W-1:0]    last_contact;
  } foot_report_t;

endpackage
`default_nettype wire

[rtl/bcq_if.sv]
`default_nettype none
interface bcq_sample_if;
  import bcq_pkg::*;
  logic         valid;
  logic         ready;
  sample_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bcq_result_if;
  import bcq_pkg::*;
  logic         valid;
  logic         ready;
  result_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/bcq_switch.sv]
`default_nettype none
module bcq_switch #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic                         pressed,
  input  wire logic [bcq_pkg::LIMIT_W-1:0]  limit,
  output logic                              qualified
);
  import bcq_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  logic [COUNT_WIDTH-1:0] hold;
  logic [COUNT_WIDTH-1:0] hold_next;

  // hold count includes the current frame, saturating
  always_comb begin
    if (pressed) begin
      hold_next = (&hold) ? hold : hold + 1'b1;
    end else begin
      hold_next = '0;
    end
  end

  assign qualified = pressed && (CMP_W'(hold_next) < CMP_W'(limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
    end else if (step) begin
      hold <= hold_next;
    end
  end

endmodule
`default_nettype wire

[rtl/bcq_foot.sv]
`default_nettype none
module bcq_foot #(
  parameter int WINDOW_LENGTH = 16,
  parameter int COUNT_WIDTH   = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step,
  input  wire logic                             raw,
  input  wire logic                             enable,
  input  wire logic [bcq_pkg::THRESHOLD_W-1:0]  threshold,
  input  wire logic [bcq_pkg::TIME_W-1:0]       now,
  output bcq_pkg::foot_report_t                 report
);
  import bcq_pkg::*;

  localparam int SUM_W     = $clog2(WINDOW_LENGTH + 1);
  localparam int CMP_W     = (SUM_W > THRESHOLD_W) ? SUM_W : THRESHOLD_W;
  localparam int RUN_CMP_W = (COUNT_WIDTH > RUN_OUT_W) ? COUNT_WIDTH : RUN_OUT_W;

  logic [WINDOW_LENGTH-1:0] win;
  logic [WINDOW_LENGTH:0]   win_ext;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-1:0]         sum_next;
  logic [COUNT_WIDTH-1:0]   run;
  logic [COUNT_WIDTH-1:0]   run_next;
  logic [RUN_CMP_W-1:0]     run_wide;
  logic [TIME_W-1:0]        last_time;
  logic [TIME_W-1:0]        last_time_next;
  logic                     hit;

  // shift line: newest bit enters at the bottom, oldest leaves at the top
  assign win_ext  = {win, raw};
  assign sum_next = sum - SUM_W'(win[WINDOW_LENGTH-1]) + SUM_W'(raw);

  always_comb begin
    if (raw) begin
      run_next = (&run) ? run : run + 1'b1;
    end else begin
      run_next = '0;
    end
  end

  assign hit            = enable && (CMP_W'(sum_next) > CMP_W'(threshold));
  assign run_wide       = RUN_CMP_W'(run_next);
  assign last_time_next = (hit && raw) ? now : last_time;

  always_comb begin
    report.contact      = hit;
    report.last_contact = last_time_next;
    if (!hit) begin
      report.run_length = '0;
    end else if (run_wide > RUN_CMP_W'({RUN_OUT_W{1'b1}})) begin
      report.run_length = {RUN_OUT_W{1'b1}};
    end else begin
      report.run_length = run_wide[RUN_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '0;
      sum       <= '0;
      run       <= '0;
      last_time <= '0;
    end else if (step) begin
      win       <= win_ext[WINDOW_LENGTH-1:0];
      sum       <= sum_next;
      run       <= run_next;
      last_time <= last_time_next;
    end
  end

endmodule
`default_nettype wire

[rtl/bumper_contact_qualifier.sv]
`default_nettype none
// channel   dir  handshake     payload
// sample    in   valid/ready   four switch bits, qualify_enable, frame_time
// result    out  valid/ready   contact, run length, last contact time per foot
// cfg       in   cfg_write     cfg_index selects register, cfg_data holds value
//
// one item per cycle sustained while results are taken; an item lands in the
// input register, then its frame is evaluated and the result register loads
// once that register is free. all state (hold counters, windows, runs, times)
// updates as the result register loads, except that a defective side's hold
// counters stay frozen.
// rst is synchronous: clears state, loads register defaults, drops valids.
// a stalled result holds the pipe; sample.ready stays high while the input
// register is empty or the result register can take the next item.
module bumper_contact_qualifier #(
  parameter int WINDOW_LENGTH = 16,
  parameter int COUNT_WIDTH   = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  bcq_sample_if.sink                             sample,
  bcq_result_if.source                           result,
  input  wire logic                              cfg_write,
  input  wire bcq_pkg::cfg_index_t               cfg_index,
  input  wire logic [bcq_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bcq_pkg::*;

  // configuration registers
  logic                   left_defect;
  logic                   right_defect;
  logic [THRESHOLD_W-1:0] threshold;
  logic [LIMIT_W-1:0]     limit;

  // input register
  logic         in_valid;
  sample_item_t in_item;

  // result register
  logic         out_valid;
  result_item_t out_item;

  logic out_load;
  logic fire;
  logic step_left;
  logic step_right;
  logic [3:0] qual;
  logic raw_left;
  logic raw_right;
  foot_report_t rep_left;
  foot_report_t rep_right;

  // result register frees when empty or taken this cycle
  assign out_load     = !out_valid || result.ready;
  assign fire         = in_valid && out_load;
  assign sample.ready = !in_valid || out_load;

  // a defective side freezes its hold counters
  assign step_left  = fire && !left_defect;
  assign step_right = fire && !right_defect;

  bcq_switch #(.COUNT_WIDTH(COUNT_WIDTH)) u_sw_lo (
    .clk(clk), .rst(rst), .step(step_left),
    .pressed(in_item.left_outer_pressed), .limit(limit), .qualified(qual[0])
  );
  bcq_switch #(.COUNT_WIDTH(COUNT_WIDTH)) u_sw_li (
    .clk(clk), .rst(rst), .step(step_left),
    .pressed(in_item.left_inner_pressed), .limit(limit), .qualified(qual[1])
  );
  bcq_switch #(.COUNT_WIDTH(COUNT_WIDTH)) u_sw_ri (
    .clk(clk), .rst(rst), .step(step_right),
    .pressed(in_item.right_inner_pressed), .limit(limit), .qualified(qual[2])
  );
  bcq_switch #(.COUNT_WIDTH(COUNT_WIDTH)) u_sw_ro (
    .clk(clk), .rst(rst), .step(step_right),
    .pressed(in_item.right_outer_pressed), .limit(limit), .qualified(qual[3])
  );

  // raw foot contact: either switch qualifies and side not defective
  assign raw_left  = !left_defect && (qual[0] || qual[1]);
  assign raw_right = !right_defect && (qual[2] || qual[3]);

  // windows and runs advance on every frame, defective or not
  bcq_foot #(.WINDOW_LENGTH(WINDOW_LENGTH), .COUNT_WIDTH(COUNT_WIDTH)) u_foot_left (
    .clk(clk), .rst(rst), .step(fire), .raw(raw_left),
    .enable(in_item.qualify_enable), .threshold(threshold),
    .now(in_item.frame_time), .report(rep_left)
  );
  bcq_foot #(.WINDOW_LENGTH(WINDOW_LENGTH), .COUNT_WIDTH(COUNT_WIDTH)) u_foot_right (
    .clk(clk), .rst(rst), .step(fire), .raw(raw_right),
    .enable(in_item.qualify_enable), .threshold(threshold),
    .now(in_item.frame_time), .report(rep_right)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      left_defect  <= 1'b0;
      right_defect <= 1'b0;
      threshold    <= THRESHOLD_RESET;
      limit        <= LIMIT_RESET;
    end else begin
      if (sample.ready) begin
        in_valid <= sample.valid;
      end
      if (out_load) begin
        out_valid <= in_valid;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_LEFT_DEFECT:  left_defect  <= cfg_data[0];
          REG_RIGHT_DEFECT: right_defect <= cfg_data[0];
          REG_THRESHOLD:    threshold    <= cfg_data[THRESHOLD_W-1:0];
          REG_LIMIT:        limit        <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_item <= sample.payload;
    end
    if (fire) begin
      out_item.contact_left       <= rep_left.contact;
      out_item.contact_right      <= rep_right.contact;
      out_item.run_length_left    <= rep_left.run_length;
      out_item.run_length_right   <= rep_right.run_length;
      out_item.last_contact_left  <= rep_left.last_contact;
      out_item.last_contact_right <= rep_right.last_contact;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_item;

endmodule
`default_nettype wire
